@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, command codes and status bundle of the heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int unsigned FFHA_HEAP_BYTES = 4096;
    localparam int unsigned HDR_BYTES       = 12;
    localparam int unsigned ALIGN_BYTES     = 8;
    localparam int unsigned CFG_W           = 13;
    localparam logic [CFG_W-1:0] CFG_RESET  = 13'd4096;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE  = 5'd0;
    localparam t_op OP_CLEAR = 5'd1;
    localparam t_op OP_LATCH = 5'd2;
    localparam t_op OP_HD0   = 5'd3;
    localparam t_op OP_HD1   = 5'd4;
    localparam t_op OP_HD2   = 5'd5;
    localparam t_op OP_HI0   = 5'd6;
    localparam t_op OP_HI1   = 5'd7;
    localparam t_op OP_HI2   = 5'd8;
    localparam t_op OP_A0    = 5'd9;
    localparam t_op OP_A1    = 5'd10;
    localparam t_op OP_A2    = 5'd11;
    localparam t_op OP_A3    = 5'd12;
    localparam t_op OP_S0    = 5'd13;
    localparam t_op OP_S1    = 5'd14;
    localparam t_op OP_S2    = 5'd15;
    localparam t_op OP_S3    = 5'd16;
    localparam t_op OP_S4    = 5'd17;
    localparam t_op OP_S5    = 5'd18;
    localparam t_op OP_FAIL  = 5'd19;
    localparam t_op OP_F0    = 5'd20;
    localparam t_op OP_M0    = 5'd21;
    localparam t_op OP_M1    = 5'd22;
    localparam t_op OP_M2    = 5'd23;
    localparam t_op OP_M3    = 5'd24;
    localparam t_op OP_M4    = 5'd25;
    localparam t_op OP_M5    = 5'd26;
    localparam t_op OP_M6    = 5'd27;
    localparam t_op OP_M7    = 5'd28;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic is_free;
        logic req_ok;
        logic hs_ok;
        logic fo_ok;
        logic head_zero;
        logic fit;
        logic split;
        logic link_ok;
        logic both_free;
        logic it_lim_a;
        logic it_lim_m;
        logic clr_last;
    } t_stat;

endpackage

@@ rtl/ffha_datapath.sv @@
// ----------------------------------------------------------------------------
// ffha_datapath
// Heap word memory, walk registers, size checks and result register.
// ----------------------------------------------------------------------------
module ffha_datapath import ffha_pkg::*; #(
    parameter int unsigned HEAP_BYTES = FFHA_HEAP_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_req_type,
    input  logic [31:0]      i_req_size,
    input  logic [11:0]      i_free_offset,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output t_stat            o_stat,
    output logic             o_done,
    output logic             o_alloc_ok,
    output logic [11:0]      o_alloc_offset
);

    localparam int unsigned NWORDS = HEAP_BYTES / 4;
    localparam int unsigned AW     = $clog2(NWORDS);
    localparam int unsigned OW     = $clog2(HEAP_BYTES);
    localparam int unsigned SW     = $clog2(HEAP_BYTES + 1);
    localparam int unsigned MAXW   = HEAP_BYTES / 12 + 2;
    localparam int unsigned ITW    = $clog2(2 * MAXW + 1);

    logic [31:0]      mem [NWORDS];
    logic [31:0]      r_rdata;

    logic [CFG_W-1:0] r_arena_len;
    logic             r_type;
    logic             r_req_ok;
    logic [31:0]      r_sz;
    logic [11:0]      r_fo;
    logic [OW-1:0]    r_cur;
    logic [OW-1:0]    r_nx;
    logic [OW-1:0]    r_nb;
    logic [31:0]      r_a;
    logic [31:0]      r_b;
    logic [31:0]      r_link;
    logic [ITW-1:0]   r_it;
    logic [AW-1:0]    r_clr;
    logic             r_done;
    logic             r_ok;
    logic [11:0]      r_off;

    logic [SW-1:0]    hs;
    logic [31:0]      fo_hdr32;
    logic [OW-1:0]    fo_hdr;
    logic [33:0]      nb34;
    logic             fit;
    logic             link_ok;
    logic             both_free;
    logic [OW-1:0]    base;
    logic [1:0]       k;
    logic [OW-1:0]    wsum;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [31:0]      mem_wdata;
    logic [31:0]      off32;

    assign hs = (32'(r_arena_len) > 32'(HEAP_BYTES)) ? SW'(HEAP_BYTES) : SW'(r_arena_len);

    assign fo_hdr32  = 32'(r_fo) - 32'(HDR_BYTES);
    assign fo_hdr    = fo_hdr32[OW-1:0];
    assign nb34      = 34'(r_cur) + 34'(HDR_BYTES) + 34'(r_sz);
    assign fit       = (r_b != 32'd0) && (r_a >= r_sz);
    assign link_ok   = (r_rdata != 32'd0) && (r_rdata[1:0] == 2'b00) &&
                       (33'(r_rdata) + 33'(HDR_BYTES) <= 33'(hs));
    assign both_free = (r_b != 32'd0) && (r_rdata != 32'd0);
    assign off32     = 32'(r_cur) + 32'(HDR_BYTES);

    always_comb begin
        o_stat.is_free   = r_type;
        o_stat.req_ok    = r_req_ok;
        o_stat.hs_ok     = 32'(hs) > 32'(HDR_BYTES);
        o_stat.fo_ok     = (32'(r_fo) >= 32'(HDR_BYTES)) && (32'(r_fo) < 32'(hs)) &&
                           (r_fo[1:0] == 2'b00);
        o_stat.head_zero = (r_a == 32'd0) && (r_b == 32'd0) && (r_rdata == 32'd0);
        o_stat.fit       = fit;
        o_stat.split     = (34'(r_a) > 34'(r_sz) + 34'(HDR_BYTES + ALIGN_BYTES)) &&
                           (nb34[1:0] == 2'b00) && (nb34 + 34'(HDR_BYTES) <= 34'(hs));
        o_stat.link_ok   = link_ok;
        o_stat.both_free = both_free;
        o_stat.it_lim_a  = r_it == ITW'(MAXW);
        o_stat.it_lim_m  = r_it == ITW'(2 * MAXW);
        o_stat.clr_last  = r_clr == AW'(NWORDS - 1);
    end

    // memory access decode: one read or one write per cycle
    always_comb begin
        base      = '0;
        k         = 2'd0;
        mem_we    = 1'b0;
        mem_wdata = 32'd0;
        unique case (i_cmd.op)
            OP_HD1, OP_HI1:               k = 2'd1;
            OP_HD2, OP_HI2:               k = 2'd2;
            OP_A0, OP_M3, OP_S3:          base = r_cur;
            OP_A1, OP_M1, OP_S5:          begin base = r_cur; k = 2'd1; end
            OP_A2, OP_M0, OP_S4:          begin base = r_cur; k = 2'd2; end
            OP_M2:                        begin base = r_nx;  k = 2'd1; end
            OP_M4:                        base = r_nx;
            OP_M6:                        begin base = r_nx;  k = 2'd2; end
            OP_S0:                        base = r_nb;
            OP_S1:                        begin base = r_nb;  k = 2'd1; end
            OP_S2:                        begin base = r_nb;  k = 2'd2; end
            OP_F0:                        begin base = fo_hdr; k = 2'd1; end
            OP_M5:                        base = r_cur;
            OP_M7:                        begin base = r_cur; k = 2'd2; end
            default:                      base = '0;
        endcase
        unique case (i_cmd.op)
            OP_CLEAR: mem_we = 1'b1;
            OP_HI0:   begin mem_we = 1'b1; mem_wdata = 32'(hs) - 32'(HDR_BYTES); end
            OP_HI1:   begin mem_we = 1'b1; mem_wdata = 32'd1; end
            OP_HI2:   mem_we = 1'b1;
            OP_S0:    begin mem_we = 1'b1; mem_wdata = r_a - r_sz - 32'(HDR_BYTES); end
            OP_S1:    begin mem_we = 1'b1; mem_wdata = 32'd1; end
            OP_S2:    begin mem_we = 1'b1; mem_wdata = r_link; end
            OP_S3:    begin mem_we = 1'b1; mem_wdata = r_sz; end
            OP_S4:    begin mem_we = 1'b1; mem_wdata = 32'(r_nb); end
            OP_S5:    mem_we = 1'b1;
            OP_F0:    begin mem_we = 1'b1; mem_wdata = 32'd1; end
            OP_M5:    begin mem_we = 1'b1; mem_wdata = r_a + 32'(HDR_BYTES) + r_rdata; end
            OP_M7:    begin mem_we = 1'b1; mem_wdata = r_rdata; end
            default:  mem_we = 1'b0;
        endcase
        wsum     = (base >> 2) + OW'(k);
        mem_addr = (i_cmd.op == OP_CLEAR) ? r_clr : wsum[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena_len <= CFG_RESET;
            r_clr       <= '0;
            r_done      <= 1'b0;
            r_ok        <= 1'b0;
            r_off       <= 12'd0;
            r_it        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_arena_len <= i_cfg_wdata;
            end
            r_done <= 1'b0;
            r_ok   <= 1'b0;
            r_off  <= 12'd0;
            unique case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + AW'(1);
                OP_LATCH: r_it <= '0;
                OP_A3:    if (!fit && link_ok) r_it <= r_it + ITW'(1);
                OP_M3:    if (!both_free) r_it <= r_it + ITW'(1);
                OP_M7:    r_it <= r_it + ITW'(1);
                OP_S5:    begin r_done <= 1'b1; r_ok <= 1'b1; r_off <= off32[11:0]; end
                OP_FAIL:  r_done <= 1'b1;
                default:  r_clr <= r_clr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_type   <= i_req_type;
                r_req_ok <= (i_req_size != 32'd0) && (i_req_size <= 32'hFFFF_FFF8);
                r_sz     <= (i_req_size + 32'(ALIGN_BYTES - 1)) & ~32'(ALIGN_BYTES - 1);
                r_fo     <= i_free_offset;
                r_cur    <= '0;
            end
            OP_HD1, OP_A1: r_a <= r_rdata;
            OP_HD2, OP_A2, OP_M2: r_b <= r_rdata;
            OP_A3: begin
                r_link <= r_rdata;
                r_nb   <= nb34[OW-1:0];
                if (!fit && link_ok) r_cur <= r_rdata[OW-1:0];
            end
            OP_M1:  r_nx <= r_rdata[OW-1:0];
            OP_M3:  if (!both_free) r_cur <= r_nx;
            OP_M4:  r_a <= r_rdata;
            default: r_a <= r_a;
        endcase
    end

    assign o_done         = r_done;
    assign o_alloc_ok     = r_ok;
    assign o_alloc_offset = r_off;

endmodule

@@ rtl/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: clearing pass, head setup, first-fit walk, merge walk.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy
);

    localparam logic [4:0] ST_CLR  = 5'd0;
    localparam logic [4:0] ST_IDLE = 5'd1;
    localparam logic [4:0] ST_CHK  = 5'd2;
    localparam logic [4:0] ST_F0   = 5'd3;
    localparam logic [4:0] ST_HD0  = 5'd4;
    localparam logic [4:0] ST_HD1  = 5'd5;
    localparam logic [4:0] ST_HD2  = 5'd6;
    localparam logic [4:0] ST_HD3  = 5'd7;
    localparam logic [4:0] ST_HI0  = 5'd8;
    localparam logic [4:0] ST_HI1  = 5'd9;
    localparam logic [4:0] ST_HI2  = 5'd10;
    localparam logic [4:0] ST_A0   = 5'd11;
    localparam logic [4:0] ST_A1   = 5'd12;
    localparam logic [4:0] ST_A2   = 5'd13;
    localparam logic [4:0] ST_A3   = 5'd14;
    localparam logic [4:0] ST_S0   = 5'd15;
    localparam logic [4:0] ST_S1   = 5'd16;
    localparam logic [4:0] ST_S2   = 5'd17;
    localparam logic [4:0] ST_S3   = 5'd18;
    localparam logic [4:0] ST_S4   = 5'd19;
    localparam logic [4:0] ST_S5   = 5'd20;
    localparam logic [4:0] ST_DONE = 5'd21;
    localparam logic [4:0] ST_M0   = 5'd22;
    localparam logic [4:0] ST_M1   = 5'd23;
    localparam logic [4:0] ST_M2   = 5'd24;
    localparam logic [4:0] ST_M3   = 5'd25;
    localparam logic [4:0] ST_M4   = 5'd26;
    localparam logic [4:0] ST_M5   = 5'd27;
    localparam logic [4:0] ST_M6   = 5'd28;
    localparam logic [4:0] ST_M7   = 5'd29;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [4:0] walk_st;

    assign walk_st = i_stat.is_free ? ST_M0 : ST_A0;

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = OP_NONE;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_stat.is_free) begin
                    n_state = i_stat.fo_ok ? ST_F0 : ST_DONE;
                end else begin
                    n_state = (i_stat.req_ok && i_stat.hs_ok) ? ST_HD0 : ST_DONE;
                end
            end
            ST_F0:  begin o_cmd.op = OP_F0;  n_state = ST_HD0; end
            ST_HD0: begin o_cmd.op = OP_HD0; n_state = ST_HD1; end
            ST_HD1: begin o_cmd.op = OP_HD1; n_state = ST_HD2; end
            ST_HD2: begin o_cmd.op = OP_HD2; n_state = ST_HD3; end
            ST_HD3: n_state = i_stat.head_zero ? ST_HI0 : walk_st;
            ST_HI0: begin o_cmd.op = OP_HI0; n_state = ST_HI1; end
            ST_HI1: begin o_cmd.op = OP_HI1; n_state = ST_HI2; end
            ST_HI2: begin o_cmd.op = OP_HI2; n_state = walk_st; end
            ST_A0: begin
                o_cmd.op = OP_A0;
                n_state  = i_stat.it_lim_a ? ST_DONE : ST_A1;
            end
            ST_A1:  begin o_cmd.op = OP_A1; n_state = ST_A2; end
            ST_A2:  begin o_cmd.op = OP_A2; n_state = ST_A3; end
            ST_A3: begin
                o_cmd.op = OP_A3;
                if (i_stat.fit) begin
                    n_state = i_stat.split ? ST_S0 : ST_S5;
                end else begin
                    n_state = i_stat.link_ok ? ST_A0 : ST_DONE;
                end
            end
            ST_S0:  begin o_cmd.op = OP_S0; n_state = ST_S1; end
            ST_S1:  begin o_cmd.op = OP_S1; n_state = ST_S2; end
            ST_S2:  begin o_cmd.op = OP_S2; n_state = ST_S3; end
            ST_S3:  begin o_cmd.op = OP_S3; n_state = ST_S4; end
            ST_S4:  begin o_cmd.op = OP_S4; n_state = ST_S5; end
            ST_S5:  begin o_cmd.op = OP_S5; n_state = ST_IDLE; end
            ST_DONE: begin o_cmd.op = OP_FAIL; n_state = ST_IDLE; end
            ST_M0: begin
                o_cmd.op = OP_M0;
                n_state  = i_stat.it_lim_m ? ST_DONE : ST_M1;
            end
            ST_M1: begin
                o_cmd.op = OP_M1;
                n_state  = i_stat.link_ok ? ST_M2 : ST_DONE;
            end
            ST_M2:  begin o_cmd.op = OP_M2; n_state = ST_M3; end
            ST_M3: begin
                o_cmd.op = OP_M3;
                n_state  = i_stat.both_free ? ST_M4 : ST_M0;
            end
            ST_M4:  begin o_cmd.op = OP_M4; n_state = ST_M5; end
            ST_M5:  begin o_cmd.op = OP_M5; n_state = ST_M6; end
            ST_M6:  begin o_cmd.op = OP_M6; n_state = ST_M7; end
            ST_M7:  begin o_cmd.op = OP_M7; n_state = ST_M0; end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = r_state != ST_IDLE;

endmodule

@@ rtl/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a heap of 32-bit words with 12-byte block headers.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  request   | start, busy             | i_req_type, i_req_size, i_free_offset
//  result    | o_done (one-cycle beat) | o_alloc_ok, o_alloc_offset
//  config    | i_cfg_we                | i_cfg_wdata (arena length)
//
//  One memory port: header words are read or written one at a time.
//  Alloc: head setup, then a walk of the block list, then split and mark.
//  Free: mark the block, head setup, then a merge walk along the list.
//  After reset a clearing pass over all HEAP_BYTES/4 heap words runs with busy high.
//  Results are not stalled; o_done pulses for one cycle per request.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int unsigned HEAP_BYTES = FFHA_HEAP_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_req_type,
    input  logic [31:0]      i_req_size,
    input  logic [11:0]      i_free_offset,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic             o_done,
    output logic             o_alloc_ok,
    output logic [11:0]      o_alloc_offset
);

    t_cmd  cmd;
    t_stat stat;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    ffha_datapath #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_alloc_ok     (o_alloc_ok),
        .o_alloc_offset (o_alloc_offset)
    );

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result beat longer than one cycle");

    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_alloc_ok |-> o_done) else $error("alloc_ok outside a result beat");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_alloc_ok |-> (o_alloc_offset == 12'd0)) else $error("offset without success");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request accepted but not busy");

endmodule

@@ tb/sv/first_fit_heap_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate and free commands into the heap allocator, predicts each
// result with a behavioral heap model and checks every result beat in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam int unsigned NWORDS   = FFHA_HEAP_BYTES / 4;
    localparam int unsigned WALK_LIM = FFHA_HEAP_BYTES / 12 + 2;
    localparam int unsigned WDOG_LIM = 200000;

    typedef struct packed {
        logic        ok;
        logic [11:0] offset;
    } t_alloc_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_req_type;
    logic [31:0]       i_req_size;
    logic [11:0]       i_free_offset;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              o_done;
    logic              o_alloc_ok;
    logic [11:0]       o_alloc_offset;

    logic [31:0]       heap_mdl [NWORDS];
    logic [CFG_W-1:0]  arena_len_mdl;
    t_alloc_res        exp_q[$];
    logic [11:0]       live_q[$];
    int                mismatches;
    int                wdog;
    bit                timed_out;

    first_fit_heap_allocator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_alloc_ok     (o_alloc_ok),
        .o_alloc_offset (o_alloc_offset)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- heap model ----------------
    function automatic logic [31:0] hrd(logic [31:0] off, int k);
        logic [31:0] idx;
        idx = (off >> 2) + k;
        return (idx < NWORDS) ? heap_mdl[idx] : 32'd0;
    endfunction

    function automatic void hwr(logic [31:0] off, int k, logic [31:0] v);
        logic [31:0] idx;
        idx = (off >> 2) + k;
        if (idx < NWORDS) heap_mdl[idx] = v;
    endfunction

    function automatic logic [31:0] usable_bytes();
        return (arena_len_mdl > FFHA_HEAP_BYTES) ? FFHA_HEAP_BYTES : arena_len_mdl;
    endfunction

    function automatic bit hdr_fits(logic [63:0] off, logic [31:0] hs);
        return (off[1:0] == 2'b00) && (off + HDR_BYTES <= {32'd0, hs});
    endfunction

    function automatic bit head_setup(logic [31:0] hs);
        if (hs <= HDR_BYTES) return 1'b0;
        if (hrd(0, 0) == 0 && hrd(0, 1) == 0 && hrd(0, 2) == 0) begin
            hwr(0, 0, hs - HDR_BYTES);
            hwr(0, 1, 32'd1);
            hwr(0, 2, 32'd0);
        end
        return 1'b1;
    endfunction

    function automatic bit link_of(logic [31:0] off, logic [31:0] hs, output logic [31:0] nx);
        logic [31:0] l;
        l = hrd(off, 2);
        nx = l;
        return (l != 0) && hdr_fits({32'd0, l}, hs);
    endfunction

    function automatic void coalesce(logic [31:0] hs);
        logic [31:0] cur, nx;
        cur = 0;
        if (!head_setup(hs)) return;
        for (int it = 0; it < 2 * WALK_LIM; it++) begin
            if (!link_of(cur, hs, nx)) break;
            if (hrd(cur, 1) != 0 && hrd(nx, 1) != 0) begin
                hwr(cur, 0, hrd(cur, 0) + HDR_BYTES + hrd(nx, 0));
                hwr(cur, 2, hrd(nx, 2));
            end else begin
                cur = nx;
            end
        end
    endfunction

    function automatic t_alloc_res first_fit(logic [31:0] req, logic [31:0] hs);
        logic [31:0] sz, cur, nx, bsz;
        logic [63:0] nb;
        t_alloc_res r;
        r = '0;
        cur = 0;
        if (req == 0 || req > 32'hFFFF_FFF8) return r;
        if (!head_setup(hs)) return r;
        sz = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
        for (int it = 0; it < WALK_LIM; it++) begin
            bsz = hrd(cur, 0);
            if (hrd(cur, 1) != 0 && bsz >= sz) begin
                nb = {32'd0, cur} + HDR_BYTES + sz;
                if ({32'd0, bsz} > {32'd0, sz} + HDR_BYTES + ALIGN_BYTES && hdr_fits(nb, hs)) begin
                    hwr(nb[31:0], 0, bsz - sz - HDR_BYTES);
                    hwr(nb[31:0], 1, 32'd1);
                    hwr(nb[31:0], 2, hrd(cur, 2));
                    hwr(cur, 0, sz);
                    hwr(cur, 2, nb[31:0]);
                end
                hwr(cur, 1, 32'd0);
                r.ok = 1'b1;
                r.offset = 12'(cur + HDR_BYTES);
                return r;
            end
            if (!link_of(cur, hs, nx)) break;
            cur = nx;
        end
        return r;
    endfunction

    function automatic t_alloc_res predict(logic rt, logic [31:0] sz, logic [11:0] fo);
        logic [31:0] hs;
        hs = usable_bytes();
        if (rt == REQ_ALLOC) return first_fit(sz, hs);
        if (fo >= HDR_BYTES && fo < hs && fo[1:0] == 2'b00) begin
            hwr(fo - HDR_BYTES, 1, 32'd1);
            coalesce(hs);
        end
        return '0;
    endfunction

    // ---------------- driving ----------------
    task automatic send_req(logic rt, logic [31:0] sz, logic [11:0] fo);
        t_alloc_res r;
        i_req_type    <= rt;
        i_req_size    <= sz;
        i_free_offset <= fo;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        r = predict(rt, sz, fo);
        exp_q.push_back(r);
        if (r.ok) live_q.push_back(r.offset);
        start <= 1'b0;
        @(posedge i_clk);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(posedge i_clk);
    endtask

    task automatic drain();
        while (exp_q.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_arena_len(logic [CFG_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        arena_len_mdl = v;
        live_q.delete();
    endtask

    task automatic alloc(logic [31:0] sz);
        send_req(REQ_ALLOC, sz, 12'($urandom));
    endtask

    task automatic free_at(logic [11:0] fo);
        send_req(REQ_FREE, 32'($urandom), fo);
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 8);
            2:       return $urandom_range(200, 1500);
            default: return $urandom_range(1, 96);
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed();
        alloc(32'd0);
        alloc(32'hFFFF_FFFF);
        alloc(32'hFFFF_FFF9);
        alloc(32'd1);
        alloc(32'd8);
        alloc(32'd9);
        alloc(32'd4000);
        alloc(32'd28);
        free_at(12'd12);
        free_at(12'd0);
        free_at(12'd13);
        free_at(12'hFFF);
        free_at(12'd32);
        free_at(12'd52);
        alloc(32'd16);
        free_at(12'd12);
        alloc(32'd4084);
        free_at(12'd12);
        alloc(32'hFFFF_FFF8);
        free_at(12'hFFC);
    endtask

    task automatic test_arena_lens();
        set_arena_len(13'd12);
        alloc(32'd1);
        free_at(12'd12);
        set_arena_len(13'd13);
        alloc(32'd1);
        set_arena_len(13'd0);
        alloc(32'd8);
        set_arena_len(13'h1FFF);
        alloc(32'd8);
        alloc(32'd5000);
        set_arena_len(13'd40);
        alloc(32'd8);
        alloc(32'd8);
        free_at(12'd12);
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && n > 0; b++, n--) begin
                if (live_q.size() != 0 && $urandom_range(0, 9) < 4) begin
                    int k;
                    k = $urandom_range(0, live_q.size() - 1);
                    free_at(live_q[k]);
                    live_q.delete(k);
                end else if ($urandom_range(0, 19) == 0) begin
                    free_at(12'($urandom));
                end else begin
                    alloc(rand_size());
                end
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    task automatic test_random();
        set_arena_len(13'd4096);
        random_phase(200);
        set_arena_len(13'($urandom_range(100, 1000)));
        random_phase(150);
        set_arena_len(13'd600);
        random_phase(100);
        set_arena_len(13'd4095);
        random_phase(100);
    endtask

    // ---------------- checking ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: ok=%0d offset=%0d", o_alloc_ok, o_alloc_offset);
            end else begin
                t_alloc_res e;
                e = exp_q.pop_front();
                if (o_alloc_ok !== e.ok || o_alloc_offset !== e.offset) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ok=%0d offset=%0d, got ok=%0d offset=%0d",
                                 e.ok, e.offset, o_alloc_ok, o_alloc_offset);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIM && !timed_out) begin
            timed_out = 1'b1;
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        wdog          = 0;
        timed_out     = 1'b0;
        arena_len_mdl = CFG_RESET;
        foreach (heap_mdl[i]) heap_mdl[i] = 32'd0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = REQ_ALLOC;
        i_req_size    = '0;
        i_free_offset = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = CFG_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_arena_lens();
        test_random();
        drain();
        if (mismatches == 0 && exp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
